### src/hed_pkg.sv
// shared constants, types and name table of the html entity decoder
package hed_pkg;

    localparam int WINDOW   = 10;
    localparam int QW       = $clog2(WINDOW + 1);
    localparam int QD       = 1 << QW;
    localparam int NNAMES   = 12;
    localparam int NAME_MAX = 5;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_XL    = 8'h78;
    localparam logic [7:0] CH_XU    = 8'h58;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PASS,
        OP_OPEN,
        OP_HOLD,
        OP_FAIL,
        OP_SCAN_START,
        OP_SCAN_STEP,
        OP_RESOLVE,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic rd_scan;
    } t_cmd;

    typedef struct packed {
        logic q_empty;
        logic scan_done;
        logic open;
        logic text_end;
        logic emit_ok;
        logic c_amp;
        logic c_semi;
        logic hold_full;
    } t_stat;

    // names left aligned in 40 bits, lower case
    function automatic logic [39:0] name_str(input logic [3:0] i);
        logic [39:0] s;
        case (i)
            4'd0:    s = {"amp", 16'h0};
            4'd1:    s = {"lt", 24'h0};
            4'd2:    s = {"gt", 24'h0};
            4'd3:    s = {"quot", 8'h0};
            4'd4:    s = {"apos", 8'h0};
            4'd5:    s = {"nbsp", 8'h0};
            4'd6:    s = "mdash";
            4'd7:    s = "ndash";
            4'd8:    s = "rsquo";
            4'd9:    s = "lsquo";
            4'd10:   s = "ldquo";
            4'd11:   s = "rdquo";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] name_len(input logic [3:0] i);
        logic [2:0] n;
        case (i)
            4'd0:                      n = 3'd3;
            4'd1, 4'd2:                n = 3'd2;
            4'd3, 4'd4, 4'd5:          n = 3'd4;
            4'd6, 4'd7, 4'd8, 4'd9,
            4'd10, 4'd11:              n = 3'd5;
            default:                   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] name_val(input logic [3:0] i);
        logic [7:0] v;
        case (i)
            4'd0:              v = CH_AMP;
            4'd1:              v = 8'h3c;
            4'd2:              v = 8'h3e;
            4'd3, 4'd10, 4'd11: v = 8'h22;
            4'd4, 4'd8, 4'd9:  v = 8'h27;
            4'd5:              v = CH_SPACE;
            4'd6, 4'd7:        v = CH_MINUS;
            default:           v = CH_AMP;
        endcase
        return v;
    endfunction

endpackage

### src/hed_if.sv
// valid/ready channels for text input beats and decoded output beats
interface hed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface hed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;

    modport source (output valid, output out_byte, output run_last, output text_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input text_done,
                    output ready);
endinterface

### src/html_entity_decoder.sv
// top level of the streaming html character reference decoder
//
// i_text carries one text byte per beat plus text_end on the last byte of a
// text. o_dec carries decoded bytes; run_last marks the last beat caused by an
// input beat and text_done the last beat of a whole text.
// an input beat is taken only while the sequencer is idle; the byte goes into
// a small circular byte queue and is then processed by one ram read and one
// decision per queued byte. a closing semicolon adds a scan of the held bytes,
// again a read and a step per held byte, then a closing read and the verdict.
// a plain byte is taken, read, decided and flushed before the next input beat
// is accepted. a failed reference rewinds the queue to the held bytes and
// replays them; at the end of a text the replays can nest.
// the last decoded byte of a beat waits in a pending register until the beat
// is finished; the output of a plain byte becomes valid once the flush moves
// it from the pending register to the output register.
// reset (synchronous, active low) empties the queue, closes any open
// reference and drops pending and output beats.
// when the receiver stalls, the output register holds; the decoder keeps
// working until it needs to move another byte out, then waits.
module html_entity_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hed_in_if.sink    i_text,
    hed_out_if.source o_dec
);
    import hed_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: decides at most one queue operation per cycle
    hed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_text.valid),
        .o_in_ready (i_text.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // queue, parser and output stage
    hed_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_text_byte (i_text.text_byte),
        .i_text_end  (i_text.text_end),
        .o_valid     (o_dec.valid),
        .i_ready     (o_dec.ready),
        .o_out_byte  (o_dec.out_byte),
        .o_run_last  (o_dec.run_last),
        .o_text_done (o_dec.text_done)
    );
endmodule

### src/hed_ram.sv
// generic single write port ram with registered read
module hed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/hed_ctrl.sv
// sequencer of the html entity decoder
module hed_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hed_pkg::t_stat i_stat,
    output hed_pkg::t_cmd  o_cmd
);
    import hed_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_SRD,
        S_SEX,
        S_RES
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_comb begin
        cmd.op      = OP_NONE;
        cmd.rd_scan = 1'b0;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.op  = OP_LOAD;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (!i_stat.q_empty) begin
                    n_state = S_EX;
                end else if (i_stat.open && i_stat.text_end) begin
                    if (i_stat.emit_ok) cmd.op = OP_FAIL;
                end else if (i_stat.emit_ok) begin
                    cmd.op  = OP_FLUSH;
                    n_state = S_IDLE;
                end
            end
            S_EX: begin
                if (!i_stat.open) begin
                    if (i_stat.c_amp) begin
                        cmd.op  = OP_OPEN;
                        n_state = S_RD;
                    end else if (i_stat.emit_ok) begin
                        cmd.op  = OP_PASS;
                        n_state = S_RD;
                    end
                end else if (i_stat.c_semi) begin
                    cmd.op  = OP_SCAN_START;
                    n_state = S_SRD;
                end else if (!i_stat.hold_full) begin
                    cmd.op  = OP_HOLD;
                    n_state = S_RD;
                end else if (i_stat.emit_ok) begin
                    cmd.op  = OP_FAIL;
                    n_state = S_RD;
                end
            end
            S_SRD: begin
                cmd.rd_scan = 1'b1;
                n_state     = i_stat.scan_done ? S_RES : S_SEX;
            end
            S_SEX: begin
                cmd.op  = OP_SCAN_STEP;
                n_state = S_SRD;
            end
            S_RES: begin
                if (i_stat.emit_ok) begin
                    cmd.op  = OP_RESOLVE;
                    n_state = S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);
endmodule

### src/hed_dp.sv
// byte queue, reference parser and output stage of the html entity decoder
module hed_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hed_pkg::t_cmd  i_cmd,
    output hed_pkg::t_stat o_stat,
    input  logic [7:0]     i_text_byte,
    input  logic           i_text_end,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_text_done
);
    import hed_pkg::*;

    typedef enum logic [2:0] {
        P_HASH,
        P_XCHK,
        P_WS,
        P_PRE,
        P_ZERO,
        P_XSEEN,
        P_DIG,
        P_STOP
    } t_phase;

    logic [QW-1:0] r_head, r_tail, r_base, r_scan;
    logic          r_open, r_end;
    logic          r_pv;
    logic [7:0]    r_pb;
    logic          r_ov, r_ol, r_od;
    logic [7:0]    r_ob;

    t_phase            r_ph, n_ph;
    logic              r_num, r_hex, r_neg, r_any;
    logic              n_num, n_hex, n_neg, n_any;
    logic [7:0]        r_v, n_v;
    logic [NNAMES-1:0] r_nm, n_nm;

    logic [7:0]    rdata;
    logic [QW-1:0] raddr, hcnt, sj;
    logic          o_free, emit_ok;
    logic          e_go;
    logic [7:0]    e_byte;
    logic          res_ok;
    logic [7:0]    res_val;

    hed_ram #(.WIDTH(8), .DEPTH(QD)) u_queue (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_LOAD),
        .i_waddr (r_tail),
        .i_wdata (i_text_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    function automatic logic is_x(input logic [7:0] c);
        return (c == CH_XL) || (c == CH_XU);
    endfunction

    function automatic logic [4:0] dval(input logic [7:0] c, input logic hex);
        logic [4:0] d;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) d = {1'b1, 4'(c - 8'h30)};
        else if (hex && c >= 8'h61 && c <= 8'h66) d = {1'b1, 4'(c - 8'h57)};
        else if (hex && c >= 8'h41 && c <= 8'h46) d = {1'b1, 4'(c - 8'h37)};
        return d;
    endfunction

    assign raddr   = i_cmd.rd_scan ? r_scan : r_head;
    assign hcnt    = r_head - r_base;
    assign sj      = r_scan - r_base;
    assign o_free  = !r_ov || i_ready;
    assign emit_ok = !r_pv || o_free;

    always_comb begin
        o_stat.q_empty   = (r_head == r_tail);
        o_stat.scan_done = (r_scan == r_head);
        o_stat.open      = r_open;
        o_stat.text_end  = r_end;
        o_stat.emit_ok   = emit_ok;
        o_stat.c_amp     = (rdata == CH_AMP);
        o_stat.c_semi    = (rdata == CH_SEMI);
        o_stat.hold_full = (hcnt >= QW'(WINDOW - 1));
    end

    // one held byte per scan step
    always_comb begin
        t_phase      ph;
        logic        done;
        logic        ws;
        logic [4:0]  dv;
        logic [11:0] mul, sum;
        logic [7:0]  lc;
        logic [39:0] s;
        int          j;
        n_ph  = r_ph;
        n_num = r_num;
        n_hex = r_hex;
        n_neg = r_neg;
        n_any = r_any;
        n_v   = r_v;
        n_nm  = r_nm;
        ph    = r_ph;
        done  = 1'b0;
        ws    = (rdata == CH_SPACE) || (rdata >= 8'd9 && rdata <= 8'd13);
        dv    = dval(rdata, r_hex);
        mul   = r_hex ? {r_v, 4'b0} : ({1'b0, r_v, 3'b0} + {3'b0, r_v, 1'b0});
        sum   = mul + {8'b0, dv[3:0]};
        lc    = (rdata >= 8'h41 && rdata <= 8'h5a) ? rdata + 8'd32 : rdata;
        j     = int'(sj);

        for (int i = 0; i < NNAMES; i++) begin
            s = name_str(4'(i));
            if (sj >= QW'(name_len(4'(i))) || j >= NAME_MAX) begin
                n_nm[i] = 1'b0;
            end else if (s[39 - 8*j -: 8] != lc) begin
                n_nm[i] = 1'b0;
            end
        end

        if (ph == P_HASH) begin
            if (rdata == CH_HASH) begin
                n_num = 1'b1;
                n_ph  = P_XCHK;
            end else begin
                n_ph = P_STOP;
            end
        end else begin
            if (ph == P_XCHK) begin
                if (is_x(rdata)) begin
                    n_hex = 1'b1;
                    n_ph  = P_WS;
                    done  = 1'b1;
                end else begin
                    ph = P_WS;
                end
            end
            if (!done && ph == P_WS) begin
                if (ws) begin
                    n_ph = P_WS;
                    done = 1'b1;
                end else if (rdata == CH_PLUS || rdata == CH_MINUS) begin
                    n_neg = (rdata == CH_MINUS);
                    n_ph  = P_PRE;
                    done  = 1'b1;
                end else begin
                    ph = P_PRE;
                end
            end
            if (!done && ph == P_PRE) begin
                done = 1'b1;
                if (r_hex && rdata == CH_ZERO) begin
                    n_any = 1'b1;
                    n_v   = '0;
                    n_ph  = P_ZERO;
                end else if (dv[4]) begin
                    n_any = 1'b1;
                    n_v   = {4'b0, dv[3:0]};
                    n_ph  = P_DIG;
                end else begin
                    n_ph = P_STOP;
                end
            end
            if (!done && ph == P_ZERO) begin
                if (is_x(rdata)) begin
                    n_ph = P_XSEEN;
                    done = 1'b1;
                end else begin
                    ph = P_DIG;
                end
            end
            if (!done && ph == P_XSEEN) begin
                done = 1'b1;
                if (dv[4]) begin
                    n_v  = {4'b0, dv[3:0]};
                    n_ph = P_DIG;
                end else begin
                    n_ph = P_STOP;
                end
            end
            if (!done && ph == P_DIG) begin
                if (dv[4]) begin
                    // saturate at 128, anything above 127 fails
                    n_v = (sum > 12'd127) ? 8'd128 : sum[7:0];
                end else begin
                    n_ph = P_STOP;
                end
            end
        end
    end

    // verdict once the scan has covered all held bytes
    always_comb begin
        res_ok  = r_num && r_any && !r_neg && (r_v != 8'd0) && !r_v[7];
        res_val = r_v;
        for (int i = NNAMES - 1; i >= 0; i--) begin
            if (r_nm[i] && (hcnt == QW'(name_len(4'(i))))) begin
                res_ok  = 1'b1;
                res_val = name_val(4'(i));
            end
        end
    end

    always_comb begin
        e_go   = 1'b0;
        e_byte = CH_AMP;
        case (i_cmd.op)
            OP_PASS: begin
                e_go   = 1'b1;
                e_byte = rdata;
            end
            OP_FAIL:    e_go = 1'b1;
            OP_RESOLVE: begin
                e_go   = 1'b1;
                e_byte = res_ok ? res_val : CH_AMP;
            end
            default:    e_go = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_base <= '0;
            r_scan <= '0;
            r_open <= 1'b0;
            r_end  <= 1'b0;
            r_pv   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            // pending beat moves to the output register, or the output drains
            if (r_pv && (e_go || i_cmd.op == OP_FLUSH)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_tail <= r_tail + 1'b1;
                    r_end  <= i_text_end;
                end
                OP_PASS, OP_HOLD: r_head <= r_head + 1'b1;
                OP_OPEN: begin
                    r_open <= 1'b1;
                    r_base <= r_head + 1'b1;
                    r_head <= r_head + 1'b1;
                end
                OP_FAIL: begin
                    r_open <= 1'b0;
                    r_head <= r_base;
                end
                OP_SCAN_START: r_scan <= r_base;
                OP_SCAN_STEP:  r_scan <= r_scan + 1'b1;
                OP_RESOLVE: begin
                    r_open <= 1'b0;
                    r_head <= res_ok ? r_head + 1'b1 : r_base;
                end
                OP_FLUSH: r_pv <= 1'b0;
                default: r_open <= r_open;
            endcase
            if (e_go) r_pv <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FLUSH && r_pv) begin
            r_ob <= r_pb;
            r_ol <= 1'b1;
            r_od <= r_end;
        end else if (e_go && r_pv) begin
            r_ob <= r_pb;
            r_ol <= 1'b0;
            r_od <= 1'b0;
        end
        if (e_go) r_pb <= e_byte;
        if (i_cmd.op == OP_SCAN_START) begin
            r_ph  <= P_HASH;
            r_num <= 1'b0;
            r_hex <= 1'b0;
            r_neg <= 1'b0;
            r_any <= 1'b0;
            r_v   <= '0;
            r_nm  <= '1;
        end else if (i_cmd.op == OP_SCAN_STEP) begin
            r_ph  <= n_ph;
            r_num <= n_num;
            r_hex <= n_hex;
            r_neg <= n_neg;
            r_any <= n_any;
            r_v   <= n_v;
            r_nm  <= n_nm;
        end
    end

    assign o_valid     = r_ov;
    assign o_out_byte  = r_ob;
    assign o_run_last  = r_ol;
    assign o_text_done = r_od;

    a_hold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (hcnt <= QW'(WINDOW - 1)))
        else $error("hold exceeds window");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QW'(r_tail - r_head) <= QW'(WINDOW)))
        else $error("queue overrun");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FLUSH) |=> !r_pv)
        else $error("pending beat left after flush");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready && r_pv) |-> !(i_cmd.op == OP_PASS || i_cmd.op == OP_FAIL ||
                                         i_cmd.op == OP_RESOLVE || i_cmd.op == OP_FLUSH))
        else $error("stalled output beat overwritten");
endmodule
